[rtl/core/ssd_pkg.sv]
package ssd_pkg;

    localparam int MaxWidth       = 1024;
    localparam int MaxDisparities = 64;
    localparam int MaxRadius      = 7;
    localparam int MaxHeight      = 1024;

    localparam logic [6:0]  DcReset  = 7'd16;
    localparam logic [2:0]  RadReset = 3'd2;
    localparam logic [10:0] WReset   = 11'd1024;
    localparam logic [10:0] HReset   = 11'd1024;

    typedef enum logic [1:0] {
        REG_DISP_COUNT = 2'd0,
        REG_RADIUS     = 2'd1,
        REG_WIDTH      = 2'd2,
        REG_HEIGHT     = 2'd3
    } t_reg_idx;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

[rtl/core/ssd_cell.sv]
module ssd_cell #(
    parameter int SumW = 16
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic            i_first,
    input  logic [7:0]      i_left,
    input  logic [7:0]      i_right,
    output logic [SumW-1:0] o_acc
);

    logic [SumW-1:0] r_acc;
    logic [SumW-1:0] n_acc;

    assign n_acc = (i_first ? '0 : r_acc) + SumW'(ssd_pkg::abs_diff(i_left, i_right));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

[rtl/core/sad_stereo_disparity.sv]
// SAD block-matching stereo disparity. Pixel pairs come in raster order and are written
// to line stores of 2*MAX_RADIUS+1 rows. For a pixel whose output is valid the stores
// are read one right sample per shift and patch entry through the single read port of
// each line store; a chain of cells, one per shift, accumulates the sums, then a compare
// pass walks the cells one a cycle once the read pipeline has drained, and the smaller
// shift wins a tie. Border and out-of-range outputs skip the search, and a stalled
// result receiver holds off new input. Write the registers only while nothing is in flight.
module sad_stereo_disparity #(
    parameter int MAX_WIDTH       = ssd_pkg::MaxWidth,
    parameter int MAX_DISPARITIES = ssd_pkg::MaxDisparities,
    parameter int MAX_RADIUS      = ssd_pkg::MaxRadius
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_left_pixel,
    input  logic [7:0]  i_right_pixel,
    input  logic        i_frame_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_disparity,
    output logic        o_valid_res,
    output logic [9:0]  o_out_row,
    output logic [9:0]  o_out_col,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam int Slots  = 2 * MAX_RADIUS + 1;
    localparam int SlotW  = $clog2(Slots + 1);
    localparam int ColW   = $clog2(MAX_WIDTH);
    localparam int Depth  = Slots * MAX_WIDTH;
    localparam int AddrW  = $clog2(Depth);
    localparam int DispW  = (MAX_DISPARITIES > 1) ? $clog2(MAX_DISPARITIES) : 1;
    localparam int DcW    = $clog2(MAX_DISPARITIES + 1);
    localparam int SumW   = $clog2(Slots * Slots * 255 + 1);
    localparam int RadW   = $clog2(MAX_RADIUS + 1);
    localparam int ChainN = MAX_DISPARITIES;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_LAST, S_CMP, S_OUT} t_state;

    logic [6:0]  r_dc_cfg;
    logic [2:0]  r_rad_cfg;
    logic [10:0] r_w_cfg;
    logic [10:0] r_h_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_cfg  <= ssd_pkg::DcReset;
            r_rad_cfg <= ssd_pkg::RadReset;
            r_w_cfg   <= ssd_pkg::WReset;
            r_h_cfg   <= ssd_pkg::HReset;
        end else if (i_cfg_we) begin
            unique case (ssd_pkg::t_reg_idx'(i_cfg_index))
                ssd_pkg::REG_DISP_COUNT: r_dc_cfg  <= i_cfg_data[6:0];
                ssd_pkg::REG_RADIUS:     r_rad_cfg <= i_cfg_data[2:0];
                ssd_pkg::REG_WIDTH:      r_w_cfg   <= i_cfg_data;
                ssd_pkg::REG_HEIGHT:     r_h_cfg   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [DcW-1:0]  dc;
    logic [RadW-1:0] rad;
    logic [12:0]     w;
    logic [10:0]     h;

    always_comb begin
        if (r_dc_cfg == 7'd0)                          dc = DcW'(1);
        else if (32'(r_dc_cfg) > MAX_DISPARITIES)      dc = DcW'(MAX_DISPARITIES);
        else                                           dc = DcW'(r_dc_cfg);
        if (32'(r_rad_cfg) > MAX_RADIUS)               rad = RadW'(MAX_RADIUS);
        else                                           rad = RadW'(r_rad_cfg);
        if (r_w_cfg == 11'd0)                          w = 13'd1;
        else if (32'(r_w_cfg) > MAX_WIDTH)             w = 13'(MAX_WIDTH);
        else                                           w = 13'(r_w_cfg);
        if (r_h_cfg == 11'd0)                          h = 11'd1;
        else if (32'(r_h_cfg) > ssd_pkg::MaxHeight)    h = 11'(ssd_pkg::MaxHeight);
        else                                           h = r_h_cfg;
    end

    logic [7:0] r_lmem [Depth];
    logic [7:0] r_rmem [Depth];

    t_state           r_state;
    logic [12:0]      r_row, r_col;
    logic [12:0]      r_lr, r_lc;
    logic [RadW:0]    r_i, r_j;
    logic [DcW-1:0]   r_k;
    logic [12:0]      r_cc;
    logic             r_rd_v, r_rd_first;
    logic [7:0]       r_lq;
    logic [7:0]       r_rq [ChainN];
    logic [SumW-1:0]  r_best_sum;
    logic [DispW-1:0] r_best_d;
    logic             r_out_v;
    logic [5:0]       r_disp;
    logic             r_vres;
    logic [9:0]       r_orow, r_ocol;
    logic             r_pend_v;
    logic [9:0]       r_prow, r_pcol;

    logic [12:0] row0, col0, row1, col1;
    logic        in_xfer, out_xfer, out_load, emit, valid_px;

    always_comb begin
        row0 = i_frame_start ? 13'd0 : r_row;
        col0 = i_frame_start ? 13'd0 : r_col;
        if (col0 >= w) begin
            col0 = 13'd0;
            row0 = row0 + 13'd1;
        end
        if (row0 >= 13'(h)) row0 = 13'd0;
        col1 = col0 + 13'd1;
        row1 = row0;
        if (col1 >= w) begin
            col1 = 13'd0;
            row1 = row0 + 13'd1;
            if (row1 >= 13'(h)) row1 = 13'd0;
        end
        emit = (row0 >= 13'(rad)) && (col0 >= 13'(rad));
        valid_px = emit && (row0 - 13'(rad) >= 13'(rad))
                   && (col0 - 13'(rad) + 13'd1 >= 13'(rad) + 13'(dc));
    end

    assign o_ready  = (r_state == S_IDLE) && !r_pend_v;
    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = r_out_v && i_ready;
    assign out_load = (r_pend_v || (r_state == S_OUT)) && (!r_out_v || i_ready);

    // row slot of (row0) modulo Slots, kept incrementally
    logic [SlotW-1:0] r_wslot;
    logic [SlotW-1:0] wslot, wslot1;
    always_comb begin
        wslot  = (row0 == 13'd0) ? '0 : ((row0 == r_row) ? r_wslot :
                 ((r_wslot == SlotW'(Slots - 1)) ? '0 : r_wslot + SlotW'(1)));
        wslot1 = (row1 == row0) ? wslot :
                 ((row1 == 13'd0) ? '0 :
                  ((wslot == SlotW'(Slots - 1)) ? '0 : wslot + SlotW'(1)));
    end

    logic [AddrW-1:0] waddr;
    assign waddr = AddrW'(32'(wslot) * MAX_WIDTH + 32'(col0[ColW-1:0]));

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_lmem[waddr] <= i_left_pixel;
            r_rmem[waddr] <= i_right_pixel;
        end
    end

    // read address: slot for the patch row and column r_cc (right shifted by r_k)
    logic [SlotW-1:0] r_rslot;
    logic [12:0]      rcol;
    logic [AddrW-1:0] laddr, raddr;
    logic             rd_step;
    assign rcol  = r_cc - 13'(r_k);
    assign laddr = AddrW'(32'(r_rslot) * MAX_WIDTH + 32'(r_cc[ColW-1:0]));
    assign raddr = AddrW'(32'(r_rslot) * MAX_WIDTH + 32'(rcol[ColW-1:0]));
    assign rd_step = (r_state == S_RD);

    logic [7:0] r_rdata;
    logic [7:0] r_ldata;
    always_ff @(posedge i_clk) begin
        if (rd_step) begin
            r_rdata <= r_rmem[raddr];
            r_ldata <= r_lmem[laddr];
        end
    end

    // load each shift's right sample into its cell, one patch entry at a time
    logic             r_shift_v, r_load_v, r_load_first;
    logic [DcW-1:0]   r_load_k;
    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_rq[r_load_k[DispW-1:0]] <= r_rdata;
            if (r_load_k == dc - DcW'(1)) r_lq <= r_ldata;
        end
    end

    logic [SumW-1:0]  acc  [ChainN];
    logic             cell_en;
    assign cell_en = r_shift_v;

    logic [DcW-1:0] r_cmp_k;
    genvar g;
    generate
        for (g = 0; g < ChainN; g++) begin : g_cell
            ssd_cell #(.SumW(SumW)) u_cell (
                .i_clk   (i_clk),
                .i_en    (cell_en),
                .i_first (r_load_first),
                .i_left  (r_lq),
                .i_right (r_rq[g]),
                .o_acc   (acc[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row     <= '0;
            r_col     <= '0;
            r_wslot   <= '0;
            r_out_v   <= 1'b0;
            r_pend_v  <= 1'b0;
            r_rd_v    <= 1'b0;
            r_load_v  <= 1'b0;
            r_shift_v <= 1'b0;
        end else begin
            r_load_v     <= r_rd_v;
            r_load_k     <= r_k;
            r_rd_v       <= rd_step;
            r_shift_v    <= r_rd_v && (r_load_k == dc - DcW'(1));
            if (out_load) r_out_v <= 1'b1;
            else if (out_xfer) r_out_v <= 1'b0;
            if (r_pend_v && out_load) begin
                r_disp   <= '0;
                r_vres   <= 1'b0;
                r_orow   <= r_prow;
                r_ocol   <= r_pcol;
                r_pend_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_row   <= row1;
                        r_col   <= col1;
                        r_wslot <= wslot1;
                        r_lr    <= row0 - 13'(rad);
                        r_lc    <= col0 - 13'(rad);
                        if (emit && !valid_px) begin
                            r_pend_v <= 1'b1;
                            r_prow   <= 10'(row0 - 13'(rad));
                            r_pcol   <= 10'(col0 - 13'(rad));
                        end else if (valid_px) begin
                            r_state <= S_RD;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_k     <= '0;
                            r_cc    <= col0 - 13'(rad) - 13'(rad);
                            r_rslot <= (wslot >= SlotW'(2 * rad)) ?
                                       wslot - SlotW'(2 * rad) :
                                       wslot + SlotW'(Slots) - SlotW'(2 * rad);
                            r_rd_first <= 1'b1;
                        end
                    end
                end
                S_RD: begin
                    // sweep shifts for one patch entry, then advance entry
                    if (r_k == dc - DcW'(1)) begin
                        r_k <= '0;
                        r_rd_first <= 1'b0;
                        if (r_j == {1'b0, rad} + {1'b0, rad}) begin
                            r_j  <= '0;
                            r_cc <= r_cc - 13'(2 * rad);
                            if (r_i == {1'b0, rad} + {1'b0, rad}) begin
                                r_state <= S_LAST;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_rslot <= (r_rslot == SlotW'(Slots - 1)) ? '0 :
                                           r_rslot + SlotW'(1);
                            end
                        end else begin
                            r_j  <= r_j + 1'b1;
                            r_cc <= r_cc + 13'd1;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_LAST: begin
                    r_state    <= S_CMP;
                    r_cmp_k    <= '0;
                    r_best_sum <= '1;
                    r_best_d   <= '0;
                end
                S_CMP: begin
                    if (!r_load_v && !r_rd_v) begin
                        if (acc[r_cmp_k[DispW-1:0]] < r_best_sum || r_cmp_k == '0) begin
                            r_best_sum <= acc[r_cmp_k[DispW-1:0]];
                            r_best_d   <= DispW'(r_cmp_k);
                        end
                        if (r_cmp_k == dc - DcW'(1)) r_state <= S_OUT;
                        else r_cmp_k <= r_cmp_k + 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_vres  <= 1'b1;
                        r_disp  <= 6'(r_best_d);
                        r_orow  <= 10'(r_lr);
                        r_ocol  <= 10'(r_lc);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic r_first_d1;
    always_ff @(posedge i_clk) begin
        r_first_d1   <= r_rd_first;
        r_load_first <= r_first_d1;
    end

    assign o_valid     = r_out_v;
    assign o_disparity = r_vres ? r_disp : 6'd0;
    assign o_valid_res = r_vres;
    assign o_out_row   = r_orow;
    assign o_out_col   = r_ocol;

    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state != S_IDLE) |-> !o_ready;
    endproperty
    assert property (p_no_accept_busy) else $error("input taken while busy");

    property p_invalid_zero;
        @(posedge i_clk) disable iff (!i_rst_n) (o_valid && !o_valid_res) |-> (o_disparity == 6'd0);
    endproperty
    assert property (p_invalid_zero) else $error("fill pixel with nonzero disparity");

    property p_disp_range;
        @(posedge i_clk) disable iff (!i_rst_n) (o_valid && o_valid_res) |-> (7'(o_disparity) < 7'(dc));
    endproperty
    assert property (p_disp_range) else $error("disparity beyond search range");

endmodule
